// File: hdl/clipped_pixel_store_fill_defines.svh
// Assertion macros used by the checker of the pixel store block.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef CLIPPED_PIXEL_STORE_FILL_DEFINES_SVH
`define CLIPPED_PIXEL_STORE_FILL_DEFINES_SVH

`define CPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define CPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/cps_pkg.sv
// Shared types and constants of the clipped pixel store.
// Used by the register block, controller, datapath, top level and checker.
package cps_pkg;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_SET   = 2'd1;
	localparam logic [1:0] OP_GET   = 2'd2;
	localparam logic [1:0] OP_FILL  = 2'd3;

	localparam logic [1:0] REG_FORMAT = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	localparam logic       FORMAT_RESET = 1'b0;
	localparam logic [7:0] WIDTH_RESET  = 8'd128;
	localparam logic [7:0] HEIGHT_RESET = 8'd128;

	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

	typedef enum logic [2:0] {
		S_INIT = 3'b001,
		S_IDLE = 3'b010,
		S_RUN  = 3'b100
	} state_t;

	typedef struct packed {
		logic init_wr;
		logic load;
		logic pix_wr;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic init_last;
		logic empty;
		logic is_get;
		logic last;
	} stat_t;

endpackage

// File: hdl/cps_regs.sv
// Configuration registers of the pixel store behind an APB-style port.
// Depends on cps_pkg for register indexes and reset values.
module cps_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic        pixel_format,
	output logic [7:0]  canvas_width,
	output logic [7:0]  canvas_height
);

	logic       wr_en;
	logic [1:0] reg_idx;
	logic       format_q;
	logic [7:0] width_q;
	logic [7:0] height_q;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= cps_pkg::FORMAT_RESET;
			width_q  <= cps_pkg::WIDTH_RESET;
			height_q <= cps_pkg::HEIGHT_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				cps_pkg::REG_FORMAT: format_q <= pwdata[0];
				cps_pkg::REG_WIDTH:  width_q  <= pwdata[7:0];
				cps_pkg::REG_HEIGHT: height_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			cps_pkg::REG_FORMAT: prdata = {31'b0, format_q};
			cps_pkg::REG_WIDTH:  prdata = {24'b0, width_q};
			cps_pkg::REG_HEIGHT: prdata = {24'b0, height_q};
			default:             prdata = '0;
		endcase
	end

	assign pixel_format  = format_q;
	assign canvas_width  = width_q;
	assign canvas_height = height_q;

endmodule

// File: hdl/cps_ctrl.sv
// Controller state machine of the pixel store: clearing pass, request
// acceptance and the per-pixel write sequence. Depends on cps_pkg.
module cps_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cps_pkg::stat_t stat,
	output cps_pkg::cmd_t  cmd,
	output logic          busy,
	output logic          done
);

	cps_pkg::state_t state_q;
	cps_pkg::state_t state_d;
	logic            done_q;
	logic            done_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		done_d  = 1'b0;
		case (state_q)
			cps_pkg::S_INIT: begin
				cmd.init_wr = 1'b1;
				if (stat.init_last) begin
					state_d = cps_pkg::S_IDLE;
				end
			end
			cps_pkg::S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = cps_pkg::S_RUN;
				end
			end
			cps_pkg::S_RUN: begin
				if (stat.empty || stat.is_get) begin
					done_d  = 1'b1;
					state_d = cps_pkg::S_IDLE;
				end else begin
					cmd.pix_wr = 1'b1;
					cmd.step   = 1'b1;
					if (stat.last) begin
						done_d  = 1'b1;
						state_d = cps_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = cps_pkg::S_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cps_pkg::S_INIT;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != cps_pkg::S_IDLE);
	assign done = done_q;

endmodule

// File: hdl/cps_dp.sv
// Datapath of the pixel store: clipping, pixel counters, address
// generation, the pixel memory and result formatting. Depends on cps_pkg.
module cps_dp #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cps_pkg::cmd_t      cmd,
	output cps_pkg::stat_t     stat,
	input  logic [1:0]         operation,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] rect_w,
	input  logic signed [15:0] rect_h,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	input  logic [7:0]         alpha,
	input  logic               pixel_format,
	input  logic [7:0]         canvas_width,
	input  logic [7:0]         canvas_height,
	output logic [7:0]         out_red,
	output logic [7:0]         out_green,
	output logic [7:0]         out_blue,
	output logic [7:0]         out_alpha,
	output logic               status
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	function automatic logic [16:0] clip(
		input logic signed [15:0] p,
		input logic signed [15:0] len,
		input logic [7:0]         lim
	);
		logic signed [17:0] pe;
		logic signed [17:0] s;
		logic signed [17:0] l;
		logic signed [17:0] lo;
		logic signed [17:0] hi;
		logic               ok;
		pe = $signed({{2{p[15]}}, p});
		s  = pe + $signed({{2{len[15]}}, len});
		l  = $signed({10'b0, lim});
		lo = (p < 0) ? '0 : pe;
		hi = (s > l) ? l : s;
		ok = (len > 0) && (lo < hi);
		return {ok, lo[7:0], hi[7:0]};
	endfunction

	logic [7:0]         eff_w;
	logic [7:0]         eff_h;
	logic signed [15:0] px;
	logic signed [15:0] py;
	logic signed [15:0] lx;
	logic signed [15:0] ly;
	logic [16:0]        cx;
	logic [16:0]        cy;
	logic [31:0]        word;

	logic [7:0]    x_q;
	logic [7:0]    y_q;
	logic [7:0]    x0_q;
	logic [7:0]    x1_q;
	logic [7:0]    y1_q;
	logic          empty_q;
	logic          is_get_q;
	logic [31:0]   word_q;
	logic [AW-1:0] init_cnt_q;
	logic [31:0]   rdata_q;
	logic [31:0]   mem [DEPTH];

	logic [8:0]    x_nxt;
	logic [8:0]    y_nxt;
	logic          row_end;
	logic [16:0]   lin;
	logic [AW-1:0] pix_addr;
	logic          show;

	assign eff_w = (32'(canvas_width) > MAX_WIDTH) ? 8'(MAX_WIDTH) : canvas_width;
	assign eff_h = (32'(canvas_height) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : canvas_height;

	// A clear is a fill of the whole canvas; set is a one-pixel fill and get reads a single pixel.
	always_comb begin
		case (operation)
			cps_pkg::OP_CLEAR: begin
				px = '0;
				py = '0;
				lx = $signed({8'b0, eff_w});
				ly = $signed({8'b0, eff_h});
			end
			cps_pkg::OP_FILL: begin
				px = pos_x;
				py = pos_y;
				lx = rect_w;
				ly = rect_h;
			end
			default: begin
				px = pos_x;
				py = pos_y;
				lx = 16'sd1;
				ly = 16'sd1;
			end
		endcase
	end

	assign cx   = clip(px, lx, eff_w);
	assign cy   = clip(py, ly, eff_h);
	assign word = pixel_format ? {24'b0, red} : {alpha, blue, green, red};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q      <= cx[15:8];
			x0_q     <= cx[15:8];
			x1_q     <= cx[7:0];
			y_q      <= cy[15:8];
			y1_q     <= cy[7:0];
			empty_q  <= !(cx[16] && cy[16]);
			is_get_q <= (operation == cps_pkg::OP_GET);
			word_q   <= word;
		end else if (cmd.step) begin
			if (row_end) begin
				x_q <= x0_q;
				y_q <= y_nxt[7:0];
			end else begin
				x_q <= x_nxt[7:0];
			end
		end
	end

	assign x_nxt   = {1'b0, x_q} + 9'd1;
	assign y_nxt   = {1'b0, y_q} + 9'd1;
	assign row_end = (x_nxt == {1'b0, x1_q});

	assign lin      = {1'b0, 16'(y_q) * 16'(eff_w)} + {9'b0, x_q};
	assign pix_addr = AW'(lin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_cnt_q <= '0;
		end else if (cmd.init_wr) begin
			init_cnt_q <= init_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init_wr) begin
			mem[init_cnt_q] <= '0;
		end else if (cmd.pix_wr) begin
			mem[pix_addr] <= word_q;
		end
		rdata_q <= mem[pix_addr];
	end

	assign stat.init_last = (init_cnt_q == AW'(DEPTH - 1));
	assign stat.empty     = empty_q;
	assign stat.is_get    = is_get_q;
	assign stat.last      = row_end && (y_nxt == {1'b0, y1_q});

	assign show      = is_get_q && !empty_q;
	assign out_red   = show ? rdata_q[7:0] : '0;
	assign out_green = show ? (pixel_format ? rdata_q[7:0] : rdata_q[15:8]) : '0;
	assign out_blue  = show ? (pixel_format ? rdata_q[7:0] : rdata_q[23:16]) : '0;
	assign out_alpha = show ? (pixel_format ? cps_pkg::ALPHA_OPAQUE : rdata_q[31:24]) : '0;
	assign status    = is_get_q && empty_q;

endmodule

// File: hdl/clipped_pixel_store_fill.sv
// Top level of the clipped pixel store with rectangle fill.
// Instantiates cps_regs, cps_ctrl and cps_dp; depends on cps_pkg.
//
// A request is taken when start is high and busy is low, and its single result
// appears on the output ports with done high for one cycle; the receiver cannot
// stall, and busy is already low in that cycle so the next request can be taken
// at once. The controller stays busy until every covered pixel of a fill or
// clear is written; a fill that covers nothing writes no pixel. Pixels are
// written one at a time through the single write port of the pixel memory.
// After reset the memory is swept to zero, one entry per cycle, through all
// MAX_WIDTH*MAX_HEIGHT entries (16384 by default) with busy high;
// configuration writes are taken during that time.
module clipped_pixel_store_fill #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] rect_w,
	input  logic signed [15:0] rect_h,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	input  logic [7:0]         alpha,
	output logic               done,
	output logic [7:0]         out_red,
	output logic [7:0]         out_green,
	output logic [7:0]         out_blue,
	output logic [7:0]         out_alpha,
	output logic               status
);

	logic           pixel_format;
	logic [7:0]     canvas_width;
	logic [7:0]     canvas_height;
	cps_pkg::cmd_t  cmd;
	cps_pkg::stat_t stat;

	cps_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.pixel_format  (pixel_format),
		.canvas_width  (canvas_width),
		.canvas_height (canvas_height)
	);

	cps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	cps_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.operation     (operation),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.rect_w        (rect_w),
		.rect_h        (rect_h),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.alpha         (alpha),
		.pixel_format  (pixel_format),
		.canvas_width  (canvas_width),
		.canvas_height (canvas_height),
		.out_red       (out_red),
		.out_green     (out_green),
		.out_blue      (out_blue),
		.out_alpha     (out_alpha),
		.status        (status)
	);

endmodule

// File: hdl/cps_checker.sv
// Port-level checker for the clipped pixel store, bound to the top level.
// Depends on cps_pkg and clipped_pixel_store_fill_defines.svh.
`include "clipped_pixel_store_fill_defines.svh"

module cps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] operation,
	input logic       done,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue,
	input logic [7:0] out_alpha,
	input logic       status
);

	logic color_zero;
	logic set_accept;

	assign color_zero = ((out_red | out_green | out_blue | out_alpha) == 8'd0);
	assign set_accept = start && !busy && (operation == cps_pkg::OP_SET);

	`CPS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
	`CPS_ASSERT_NOW(a_done_idle, done, !busy, "result shown while still busy")
	`CPS_ASSERT_NOW(a_oor_zero, done && status, color_zero, "out-of-canvas read has nonzero color")
	`CPS_ASSERT_NOW(a_set_latency, set_accept, ##2 done, "set request result not two cycles later")

endmodule

bind clipped_pixel_store_fill cps_checker u_checker (.*);
